### design/ptg_pkg.sv
// ----------------------------------------------------------------------------
// ptg_pkg: shared types and constants of the pulse-train generator
// Item and result payloads, the channel table entry and the step result.
// ----------------------------------------------------------------------------
package ptg_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [7:0] UNLIMITED_PULSES = 8'hFF;

    localparam logic [1:0] FUNC_SCAN   = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_ENABLE = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  channel;
        logic        enable;
        logic [7:0]  pulse_count;
        logic [31:0] interval;
        logic [15:0] edge_count;
        logic [15:0] cycle_length;
        logic [15:0] start_phase;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic [2:0] channel_out;
        logic       level;
        logic       last;
    } result_t;

    // one channel table entry
    typedef struct packed {
        logic [7:0]  pulses_left;
        logic [31:0] step_interval;
        logic [15:0] high_limit;
        logic [15:0] cycle_limit;
        logic [15:0] phase;
        logic [31:0] last_step_time;
        logic        out_level;
    } entry_t;

    typedef struct packed {
        logic   fire;
        logic   level;
        entry_t next;
    } step_t;

endpackage

### design/ptg_chan_mem.sv
// ----------------------------------------------------------------------------
// ptg_chan_mem: channel table memory
// One write port, one registered read port; per-entry valid bits make an
// entry that was never written read as all zero.
// ----------------------------------------------------------------------------
module ptg_chan_mem
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [ptg_pkg::CH_W-1:0]    rd_addr,
    output ptg_pkg::entry_t             rd_data,
    input  logic                        wr_en,
    input  logic [ptg_pkg::CH_W-1:0]    wr_addr,
    input  ptg_pkg::entry_t             wr_data
);

    ptg_pkg::entry_t                  mem [ptg_pkg::CHANNELS];
    ptg_pkg::entry_t                  rd_q_reg;
    logic [ptg_pkg::CHANNELS-1:0]     valid_reg;
    logic                             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

### design/ptg_step_unit.sv
// ----------------------------------------------------------------------------
// ptg_step_unit: one channel step
// Decides whether a channel steps at the scan time and computes its level
// and the updated table entry.
// ----------------------------------------------------------------------------
module ptg_step_unit
(
    input  ptg_pkg::entry_t  entry,
    input  logic             chan_on,
    input  logic [31:0]      now,
    output ptg_pkg::step_t   step
);

    logic [31:0] elapsed;
    logic [15:0] phase_inc;
    logic        wrap;

    always_comb
    begin
        elapsed   = now - entry.last_step_time;
        phase_inc = entry.phase + 16'd1;
        wrap      = phase_inc > entry.cycle_limit;

        step.fire  = chan_on && (entry.pulses_left != 8'd0)
                     && (elapsed >= entry.step_interval);
        step.level = entry.phase <= entry.high_limit;

        step.next                = entry;
        step.next.last_step_time = now;
        step.next.out_level      = step.level;
        step.next.phase          = wrap ? 16'd0 : phase_inc;
        if (wrap && entry.pulses_left != ptg_pkg::UNLIMITED_PULSES)
        begin
            step.next.pulses_left = entry.pulses_left - 8'd1;
        end
    end

endmodule

### design/multichannel_pulse_train_generator_top.sv
// ----------------------------------------------------------------------------
// multichannel_pulse_train_generator_top: pulse-train channel table
// Load, enable and scan items against a table of pulse-train channels held
// in a synchronous memory; a scan steps each due channel once.
//
//   channel   direction  payload   handshake
//   item      in         item_t    item_valid / item_ready
//   result    out        result_t  result_valid / result_ready
//
// enable items are applied at accept; load items read the memory, then write back
// a scan passes through the accept, one memory read per channel (written back
//   when the channel fires), and the flush state that sends the final result
// a stalled result port holds the scan on its current channel
// reset clears enables and the table valid bits, so every entry reads zero
// ----------------------------------------------------------------------------
module multichannel_pulse_train_generator_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ptg_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output ptg_pkg::result_t  result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    localparam logic [ptg_pkg::CH_W-1:0] LAST_CH = ptg_pkg::CH_W'(ptg_pkg::CHANNELS - 1);

    logic [1:0]                       state_reg, state_next;
    logic [ptg_pkg::CH_W-1:0]         cur_reg, cur_next;
    logic [ptg_pkg::CHANNELS-1:0]     enable_reg;
    ptg_pkg::item_t                   item_reg;
    logic                             pend_valid_reg, pend_valid_next;
    logic [2:0]                       pend_ch_reg;
    logic                             pend_lvl_reg;
    logic                             result_valid_reg, result_valid_next;
    ptg_pkg::result_t                 result_reg;

    logic                             accept;
    logic                             in_range;
    logic                             rd_en, wr_en;
    logic [ptg_pkg::CH_W-1:0]         rd_addr, wr_addr;
    ptg_pkg::entry_t                  rd_data, wr_data, load_entry;
    ptg_pkg::step_t                   step;
    logic                             out_free, stall, advance;
    logic                             push_mid, push_last;

    ptg_chan_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ptg_step_unit u_step
    (
        .entry   (rd_data),
        .chan_on (enable_reg[cur_reg]),
        .now     (item_reg.now),
        .step    (step)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign in_range     = 32'(item.channel) < ptg_pkg::CHANNELS;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign out_free  = !result_valid_reg || result_ready;
    assign stall     = step.fire && pend_valid_reg && !out_free;
    assign advance   = (state_reg == S_SCAN) && !stall;
    assign push_mid  = advance && step.fire && pend_valid_reg;
    assign push_last = (state_reg == S_FLUSH) && pend_valid_reg && out_free;

    // memory read port: first entry at scan accept, the addressed entry at load accept, next entry while scanning
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (state_reg == S_SCAN)
        begin
            rd_en   = advance && (cur_reg != LAST_CH);
            rd_addr = cur_reg + 1'b1;
        end
        else if (accept)
        begin
            rd_en   = (item.func == ptg_pkg::FUNC_SCAN)
                      || ((item.func == ptg_pkg::FUNC_LOAD) && in_range);
            rd_addr = (item.func == ptg_pkg::FUNC_LOAD) ? ptg_pkg::CH_W'(item.channel) : '0;
        end
    end

    always_comb
    begin
        load_entry               = rd_data;
        load_entry.pulses_left   = item_reg.pulse_count;
        load_entry.step_interval = item_reg.interval;
        load_entry.high_limit    = item_reg.edge_count;
        load_entry.cycle_limit   = item_reg.cycle_length;
        load_entry.phase         = item_reg.start_phase;
    end

    always_comb
    begin
        if (state_reg == S_LOAD)
        begin
            wr_en   = 1'b1;
            wr_addr = ptg_pkg::CH_W'(item_reg.channel);
            wr_data = load_entry;
        end
        else
        begin
            wr_en   = advance && step.fire;
            wr_addr = cur_reg;
            wr_data = step.next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.func == ptg_pkg::FUNC_SCAN)
                begin
                    state_next = S_SCAN;
                    cur_next   = '0;
                end
                else if (accept && item.func == ptg_pkg::FUNC_LOAD && in_range)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    if (cur_reg == LAST_CH)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (advance && step.fire)
        begin
            pend_valid_next = 1'b1;
        end
        else if (push_last)
        begin
            pend_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (push_mid || push_last)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cur_reg          <= '0;
            enable_reg       <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_reg          <= cur_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            if (accept && item.func == ptg_pkg::FUNC_ENABLE && in_range)
            begin
                enable_reg[ptg_pkg::CH_W'(item.channel)] <= item.enable;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (advance && step.fire)
        begin
            pend_ch_reg  <= 3'(cur_reg);
            pend_lvl_reg <= step.level;
        end
        if (push_mid || push_last)
        begin
            result_reg.channel_out <= pend_ch_reg;
            result_reg.level       <= pend_lvl_reg;
            result_reg.last        <= push_last;
        end
    end

    // a scan never returns to idle with a result still held back
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left behind at end of scan");

    // the scan visits channels in order, one per advancing cycle
    a_cur_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cur_reg != LAST_CH |=> cur_reg == $past(cur_reg) + 1'b1)
        else $error("scan channel did not advance by one");

    // a stalled scan keeps the entry it is working on
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && stall |=> $stable(rd_data) && state_reg == S_SCAN)
        else $error("table entry changed during stall");

    // the final result of a scan is only sent from the flush state
    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        push_mid |-> !push_last && state_reg == S_SCAN)
        else $error("mid-scan transfer outside scan state");

    // pending pushes never overwrite an unsent result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (push_mid || push_last) |-> out_free)
        else $error("result register overwritten before transfer");

endmodule
